// ===== sv/sorted_priority_queue_macros.svh =====
// ----------------------------------------------------------------------------
// sorted priority queue assertion macros
// shared assertion forms for the queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// checked outside reset only
`define SPQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// types and codes shared by the sorted priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

	localparam int VALUE_W  = 32;
	localparam int PRIO_W   = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic        [PRIO_W-1:0]  prio;
	} entry_t;

	// broadcast from the control to every cell
	typedef struct packed {
		logic   ins;
		logic   rem;
		entry_t fresh;
	} cell_ctrl_t;

endpackage

// ===== sv/spq_ifs.sv =====
// ----------------------------------------------------------------------------
// spq channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spq_req_if;
	logic                                      valid;
	logic                                      ready;
	logic                                      op;
	logic signed [spq_pkg::VALUE_W-1:0]        item_value;
	logic        [spq_pkg::PRIO_W-1:0]         item_priority;

	modport source (output valid, output op, output item_value, output item_priority,
		input ready);
	modport sink (input valid, input op, input item_value, input item_priority,
		output ready);
endinterface

interface spq_rsp_if;
	logic                                      valid;
	logic                                      ready;
	logic        [spq_pkg::STATUS_W-1:0]       status;
	logic signed [spq_pkg::VALUE_W-1:0]        removed_value;
	logic        [spq_pkg::PRIO_W-1:0]         removed_priority;
	logic        [spq_pkg::OCC_W-1:0]          occupancy;

	modport source (output valid, output status, output removed_value,
		output removed_priority, output occupancy, input ready);
	modport sink (input valid, input status, input removed_value,
		input removed_priority, input occupancy, output ready);
endinterface

// ===== sv/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted array; keeps, takes the new entry or shifts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occ,
	input  logic                left_holds,
	input  spq_pkg::entry_t     left_entry,
	input  spq_pkg::entry_t     right_entry,
	output spq_pkg::entry_t     entry,
	output logic                holds
);

	spq_pkg::entry_t entry_q;
	spq_pkg::entry_t entry_d;

	// held entry stays ahead of an equal or larger new priority
	assign holds = occ && (entry_q.prio <= ctrl.fresh.prio);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctrl.ins) begin
			if (holds) begin
				entry_d = entry_q;
			end else if (left_holds) begin
				entry_d = ctrl.fresh;
			end else begin
				entry_d = left_entry;
			end
		end else if (ctrl.rem) begin
			entry_d = right_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// priority queue held as a sorted row of cells, smallest priority in front
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   op, item_value, item_priority
//  rsp      out  status, removed_value, removed_priority, occupancy
//
//  one transaction per cycle unless rsp stalls: every cell decides its next
//  entry from its neighbors and the broadcast request
//  response is registered; a new request is taken while rsp is empty or taken
//  rsp stall holds req off through ready
//  reset empties the queue at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                accept;
	logic                full;
	logic                empty;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::entry_t     ent   [CAPACITY];
	logic                holds [CAPACITY];

	logic                                 rsp_valid_q;
	logic [spq_pkg::STATUS_W-1:0]         status_q;
	logic signed [spq_pkg::VALUE_W-1:0]   removed_value_q;
	logic [spq_pkg::PRIO_W-1:0]           removed_priority_q;
	logic [spq_pkg::OCC_W-1:0]            occupancy_q;

	assign full  = (count_q == CNT_W'(CAPACITY));
	assign empty = (count_q == '0);

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign ctrl.ins         = accept && (req.op == spq_pkg::OP_INSERT) && !full;
	assign ctrl.rem         = accept && (req.op == spq_pkg::OP_REMOVE) && !empty;
	assign ctrl.fresh.value = req.item_value;
	assign ctrl.fresh.prio  = req.item_priority;

	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CNT_W'(1);
		end else if (ctrl.rem) begin
			count_d = count_q - CNT_W'(1);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic            left_holds;
			spq_pkg::entry_t left_entry;
			spq_pkg::entry_t right_entry;

			if (gi == 0) begin : g_head
				assign left_holds = 1'b1;
				assign left_entry = ctrl.fresh;
			end else begin : g_mid
				assign left_holds = holds[gi-1];
				assign left_entry = ent[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_tail
				assign right_entry = '0;
			end else begin : g_body
				assign right_entry = ent[gi+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.ctrl        (ctrl),
				.occ         (CNT_W'(gi) < count_q),
				.left_holds  (left_holds),
				.left_entry  (left_entry),
				.right_entry (right_entry),
				.entry       (ent[gi]),
				.holds       (holds[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q           <= spq_pkg::ST_DONE;
			removed_value_q    <= '0;
			removed_priority_q <= '0;
			occupancy_q        <= spq_pkg::OCC_W'(count_d);
			if (req.op == spq_pkg::OP_INSERT) begin
				if (full) begin
					status_q <= spq_pkg::ST_OVERFLOW;
				end
			end else begin
				if (empty) begin
					status_q <= spq_pkg::ST_UNDERFLOW;
				end else begin
					removed_value_q    <= ent[0].value;
					removed_priority_q <= ent[0].prio;
				end
			end
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = status_q;
	assign rsp.removed_value    = removed_value_q;
	assign rsp.removed_priority = removed_priority_q;
	assign rsp.occupancy        = occupancy_q;

	`SPQ_ASSERT_ALWAYS(a_count_bound, (!arst_n || count_q <= CNT_W'(CAPACITY)), "count above capacity")
	`SPQ_ASSERT(a_overflow, (accept && req.op == spq_pkg::OP_INSERT && full) |=> (rsp.valid && rsp.status == spq_pkg::ST_OVERFLOW && $stable(count_q)), "overflow not reported")
	`SPQ_ASSERT(a_remove_count, (ctrl.rem) |=> (count_q == $past(count_q) - CNT_W'(1)), "remove did not drop count")
	`SPQ_ASSERT(a_front_sorted, (count_q >= CNT_W'(2)) |-> (ent[0].prio <= ent[1].prio), "front entries out of order")

endmodule
